/* src/eppk_pkg.sv */
// ----------------------------------------------------------------------------
// eppk_pkg: shared types and constants of the two-plane pixel packer
// Item codes, register indexes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package eppk_pkg;

	// item codes
	localparam logic [1:0] CMD_WRITE        = 2'd0;
	localparam logic [1:0] CMD_READ         = 2'd1;
	localparam logic [1:0] CMD_REFRESH_DONE = 2'd2;

	// register indexes
	localparam logic [1:0] REG_WIDTH       = 2'd0;
	localparam logic [1:0] REG_HEIGHT      = 2'd1;
	localparam logic [1:0] REG_ORIENTATION = 2'd2;

	// panel limits and fixed values
	localparam int MAX_WIDTH  = 176;
	localparam int MAX_HEIGHT = 296;
	localparam logic [7:0]  WIDTH_RESET  = 8'd128;
	localparam logic [8:0]  HEIGHT_RESET = 9'd296;
	localparam logic [16:0] COUNT_MAX    = 17'h1FFFF;
	localparam logic [7:0]  BLACK_RESET  = 8'hFF;
	localparam logic [7:0]  RED_RESET    = 8'h00;
	localparam logic [7:0]  MSB_MASK     = 8'h80;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_RD,
		ST_MOD,
		ST_EMIT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;    // capture the input item
		logic mul_addr;  // multiply the address terms
		logic calc_sum;  // form the byte address, multiply the panel area
		logic rd;        // read both planes at the byte address
		logic wr;        // write back the modified bytes
		logic clr_wr;    // write one entry of the clearing pass
		logic emit;      // finish the item: update counts, load the result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_read;
		logic area_last;
		logic clr_last;
		logic out_free;
	} dp_stat_t;

endpackage

/* src/eppk_ctrl.sv */
// ----------------------------------------------------------------------------
// eppk_ctrl: sequencer of the pixel packer
// Steps a write through address calculation, plane read-modify-write and
// delivery; a read through plane read and delivery. Clears planes after reset.
// ----------------------------------------------------------------------------
module eppk_ctrl import eppk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] cmd,
	input  dp_stat_t   stat,
	output logic       in_stall,
	output dp_cmd_t    ctl
);

	ctrl_state_t state_q, state_d;
	logic        need_result;

	assign need_result = stat.is_read || stat.area_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_WRITE) state_d = ST_MUL;
					else if (cmd == CMD_READ) state_d = ST_RD;
				end
			end
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_RD;
			ST_RD:   state_d = stat.is_read ? ST_EMIT : ST_MOD;
			ST_MOD:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (!need_result || stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: ctl.clr_wr = 1'b1;
			ST_IDLE: begin
				in_stall   = 1'b0;
				ctl.accept = in_valid;
			end
			ST_MUL:  ctl.mul_addr = 1'b1;
			ST_SUM:  ctl.calc_sum = 1'b1;
			ST_RD:   ctl.rd = 1'b1;
			ST_MOD:  ctl.wr = 1'b1;
			ST_EMIT: ctl.emit = !need_result || stat.out_free;
			default: ctl = '0;
		endcase
	end

endmodule

/* src/eppk_dp.sv */
// ----------------------------------------------------------------------------
// eppk_dp: datapath of the pixel packer
// Registers, address arithmetic on one shared multiplier, the two plane
// memories, pixel and refresh accounting, and the output register.
// ----------------------------------------------------------------------------
module eppk_dp import eppk_pkg::*; #(
	parameter int PLANE_BYTES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     ctl,
	output dp_stat_t    stat,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic [1:0]  cmd,
	input  logic [8:0]  pix_x,
	input  logic [8:0]  pix_y,
	input  logic [1:0]  color,
	input  logic        area_last,
	input  logic [12:0] byte_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_read_data,
	output logic [7:0]  black_byte,
	output logic [7:0]  red_byte,
	output logic        refresh_request,
	output logic        full_refresh
);

	localparam int ADDR_W = $clog2(PLANE_BYTES);
	localparam logic [17:0] PLANE_LIM = 18'(PLANE_BYTES);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(PLANE_BYTES - 1);

	logic [7:0]  black_mem [PLANE_BYTES];
	logic [7:0]  red_mem   [PLANE_BYTES];

	logic [7:0]  width_q;
	logic [8:0]  height_q;
	logic [1:0]  orient_q;
	logic [16:0] cnt_q;
	logic        full_q;
	logic        out_valid_q;
	logic [ADDR_W-1:0] clr_q;

	logic [1:0]  cmd_q;
	logic [8:0]  x_q, y_q;
	logic [1:0]  color_q;
	logic        last_q;
	logic [17:0] addr_q, prod_q, area_q;
	logic [2:0]  bit_q;
	logic [7:0]  black_rd_q, red_rd_q;
	logic        is_read_q, refresh_q, full_out_q;
	logic [7:0]  black_out_q, red_out_q;

	logic [2:0]  pad;
	logic        col_major, x_down;
	logic [9:0]  xc, yc;
	logic [5:0]  stride;
	logic [8:0]  mul_a, mul_b;
	logic [17:0] mul_p;
	logic [17:0] offset;
	logic [2:0]  bit_sel;
	logic        in_range;
	logic [7:0]  mask, black_new, red_new;
	logic [16:0] cnt_inc;
	logic        full_now;
	logic [ADDR_W-1:0] mem_addr;

	assign pad       = 3'd7 - (width_q[2:0] - 3'd1);
	assign col_major = orient_q[0];
	assign x_down    = orient_q[1];
	assign xc        = {1'b0, x_q} + (x_down ? {7'd0, pad} : 10'd0);
	assign yc        = {1'b0, y_q} + (x_down ? {7'd0, pad} : 10'd0);
	assign stride    = 6'(({1'b0, width_q} + 9'd7) >> 3);

	always_comb begin
		if (ctl.calc_sum) begin
			mul_a = {1'b0, width_q};
			mul_b = height_q;
		end else if (col_major) begin
			mul_a = {2'b00, yc[9:3]};
			mul_b = height_q;
		end else begin
			mul_a = y_q;
			mul_b = {3'b000, stride};
		end
	end

	assign mul_p   = mul_a * mul_b;
	assign offset  = col_major ? {9'd0, x_q} : {11'd0, xc[9:3]};
	assign bit_sel = col_major ? yc[2:0] : xc[2:0];

	assign in_range  = addr_q < PLANE_LIM;
	assign mask      = MSB_MASK >> bit_q;
	assign black_new = color_q[0] ? (black_rd_q | mask) : (black_rd_q & ~mask);
	assign red_new   = color_q[1] ? (red_rd_q | mask) : (red_rd_q & ~mask);

	assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 17'd1;
	assign full_now = full_q || ({1'b0, cnt_inc} >= area_q);

	assign mem_addr = ctl.clr_wr ? clr_q : addr_q[ADDR_W-1:0];

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RESET;
			height_q    <= HEIGHT_RESET;
			orient_q    <= 2'd0;
			cnt_q       <= '0;
			full_q      <= 1'b1;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			if (ctl.clr_wr) clr_q <= clr_q + ADDR_W'(1);
			// load a new result, else drop the one taken by the receiver
			if (ctl.emit && (cmd_q == CMD_READ || last_q)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.accept && cmd == CMD_REFRESH_DONE && full_q) begin
				cnt_q  <= '0;
				full_q <= 1'b0;
			end
			if (ctl.emit && cmd_q != CMD_READ) begin
				cnt_q <= cnt_inc;
				if (last_q) full_q <= full_now;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH: begin
						width_q <= ({1'b0, cfg_data[7:0]} > 9'(MAX_WIDTH)) ?
							8'(MAX_WIDTH) : cfg_data[7:0];
						full_q  <= 1'b1;
					end
					REG_HEIGHT: begin
						height_q <= ({1'b0, cfg_data} > 10'(MAX_HEIGHT)) ?
							9'(MAX_HEIGHT) : cfg_data;
						full_q   <= 1'b1;
					end
					REG_ORIENTATION: begin
						orient_q <= cfg_data[1:0];
						full_q   <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// item payload and arithmetic
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q   <= cmd;
			x_q     <= pix_x;
			y_q     <= pix_y;
			color_q <= color;
			last_q  <= area_last;
			addr_q  <= {5'd0, byte_index};
		end
		if (ctl.mul_addr) prod_q <= mul_p;
		if (ctl.calc_sum) begin
			addr_q <= offset + prod_q;
			bit_q  <= bit_sel;
			area_q <= mul_p;
		end
		if (ctl.emit) begin
			if (cmd_q == CMD_READ) begin
				is_read_q   <= 1'b1;
				black_out_q <= in_range ? black_rd_q : 8'd0;
				red_out_q   <= in_range ? red_rd_q : 8'd0;
				refresh_q   <= 1'b0;
				full_out_q  <= 1'b0;
			end else if (last_q) begin
				is_read_q   <= 1'b0;
				black_out_q <= 8'd0;
				red_out_q   <= 8'd0;
				refresh_q   <= 1'b1;
				full_out_q  <= full_now;
			end
		end
	end

	// plane memories: one write port shared by clearing and write-back
	always_ff @(posedge clk) begin
		if (ctl.clr_wr) begin
			black_mem[mem_addr] <= BLACK_RESET;
			red_mem[mem_addr]   <= RED_RESET;
		end else if (ctl.wr && in_range) begin
			black_mem[mem_addr] <= black_new;
			red_mem[mem_addr]   <= red_new;
		end
		if (ctl.rd) begin
			black_rd_q <= black_mem[mem_addr];
			red_rd_q   <= red_mem[mem_addr];
		end
	end

	assign stat.is_read   = cmd_q == CMD_READ;
	assign stat.area_last = last_q;
	assign stat.clr_last  = clr_q == CLR_LAST;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign is_read_data    = is_read_q;
	assign black_byte      = black_out_q;
	assign red_byte        = red_out_q;
	assign refresh_request = refresh_q;
	assign full_refresh    = full_out_q;

endmodule

/* src/epaper_two_plane_pixel_packer.sv */
// ----------------------------------------------------------------------------
// epaper_two_plane_pixel_packer: two-plane e-paper frame buffer packer
// Packs 2-bit pixels into a black/white and a red bit plane, serves plane
// byte reads and raises refresh requests at the end of drawn areas.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one item: a pixel write, a plane
//   byte read or a refresh-completed notice. Output channel (out_valid /
//   out_stall) returns read bytes or a refresh request.
//   Configuration: pulse cfg_we with cfg_index / cfg_data while idle; width
//   and height saturate at panel limits, a register write forces full refresh.
//   Sequence: a write steps through multiply, add, plane read, write-back and
//   result, a read through plane read and result, a refresh-completed notice
//   ends at acceptance. The write steps follow from the multiply-then-add
//   address calculation and the read-modify-write on single-port planes.
//   Latency: a result appears on out_valid the cycle after its last step.
//   Reset: the planes are swept to white / no red, one byte a cycle, over
//   all PLANE_BYTES entries; in_stall stays high meanwhile, configuration
//   writes are still taken.
//   Stall: a waiting result holds in the output register; the next item is
//   still accepted and only blocks when it too has a result to deliver.
// ----------------------------------------------------------------------------
module epaper_two_plane_pixel_packer import eppk_pkg::*; #(
	parameter int PLANE_BYTES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [8:0]  pix_x,
	input  logic [8:0]  pix_y,
	input  logic [1:0]  color,
	input  logic        area_last,
	input  logic [12:0] byte_index,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_read_data,
	output logic [7:0]  black_byte,
	output logic [7:0]  red_byte,
	output logic        refresh_request,
	output logic        full_refresh
);

	dp_cmd_t  ctl;
	dp_stat_t stat;

	// sequencer: steps each item and the clearing pass
	eppk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.stat     (stat),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	// datapath: registers, address arithmetic, planes and output register
	eppk_dp #(
		.PLANE_BYTES (PLANE_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.pix_x           (pix_x),
		.pix_y           (pix_y),
		.color           (color),
		.area_last       (area_last),
		.byte_index      (byte_index),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.is_read_data    (is_read_data),
		.black_byte      (black_byte),
		.red_byte        (red_byte),
		.refresh_request (refresh_request),
		.full_refresh    (full_refresh)
	);

`ifndef SYNTHESIS
	// a result is either read data or a refresh request, never both
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_read_data != refresh_request))
		else $error("result kind is ambiguous");

	// read data never asks for a full refresh
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_read_data |-> !full_refresh)
		else $error("full refresh flagged on read data");

	// a write or read item keeps the input stalled while it is worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_WRITE || cmd == CMD_READ) |=> in_stall)
		else $error("input accepted while an item is in progress");
`endif

endmodule
